FILE: sv/bfiq_pkg.sv
// Shared constants and register codes for the Bloom filter engine.
`default_nettype none
package bfiq_pkg;

  localparam int unsigned MAX_FILTER_BITS_DEF = 1048576;
  localparam int unsigned MAX_PROBES_DEF      = 32;

  localparam int unsigned NUM_BITS_W    = 21;
  localparam int unsigned HASH_COUNT_W  = 6;
  localparam int unsigned CFG_DATA_W    = 21;
  localparam int unsigned CFG_INDEX_W   = 2;
  localparam int unsigned HASH_W        = 64;
  localparam int unsigned WORD_W        = 64;

  localparam logic [HASH_W-1:0] DJB2_SEED = 64'd5381;
  localparam logic [HASH_W-1:0] SDBM_SEED = 64'd0;

  localparam logic [NUM_BITS_W-1:0]   NUM_BITS_RST   = 21'h100000;
  localparam logic [HASH_COUNT_W-1:0] HASH_COUNT_RST = 6'd7;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_NUM_BITS   = 2'd0,
    REG_HASH_COUNT = 2'd1
  } reg_index_t;

endpackage
`default_nettype wire

FILE: sv/bfiq_hash.sv
// Running djb2 and sdbm hashes over the key bytes.
`default_nettype none
module bfiq_hash (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        upd,
  input  logic [7:0]                  key_byte,
  input  logic                        last_byte,
  output logic [bfiq_pkg::HASH_W-1:0] djb_nxt,
  output logic [bfiq_pkg::HASH_W-1:0] sdbm_nxt
);
  import bfiq_pkg::*;

  logic [HASH_W-1:0] djb_r;
  logic [HASH_W-1:0] sdbm_r;
  logic [HASH_W-1:0] byte_ext;

  assign byte_ext = {{(HASH_W-8){1'b0}}, key_byte};
  assign djb_nxt  = (djb_r << 5) + djb_r + byte_ext;
  assign sdbm_nxt = byte_ext + (sdbm_r << 6) + (sdbm_r << 16) - sdbm_r;

  // Both hashes go back to their seeds once a key is complete.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      djb_r  <= DJB2_SEED;
      sdbm_r <= SDBM_SEED;
    end else if (upd) begin
      if (last_byte) begin
        djb_r  <= DJB2_SEED;
        sdbm_r <= SDBM_SEED;
      end else begin
        djb_r  <= djb_nxt;
        sdbm_r <= sdbm_nxt;
      end
    end
  end

endmodule
`default_nettype wire

FILE: sv/bfiq_modulo.sv
// Bit-serial restoring remainder of a 64-bit value by the filter size.
`default_nettype none
module bfiq_modulo #(
  parameter int unsigned MW = 21
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        go,
  input  logic [bfiq_pkg::HASH_W-1:0] dividend,
  input  logic [MW-1:0]               divisor,
  output logic                        done,
  output logic [MW-1:0]               rem
);
  import bfiq_pkg::*;

  localparam int unsigned CW = $clog2(HASH_W);

  logic [HASH_W-1:0] div_r;
  logic [MW-1:0]     dsr_r;
  logic [MW-1:0]     rem_r;
  logic [CW-1:0]     cnt_r;
  logic              run_r;
  logic              done_r;
  logic [MW:0]       sh;
  logic [MW:0]       sub;

  assign sh  = {rem_r, div_r[HASH_W-1]};
  assign sub = sh - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(HASH_W-1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      div_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (run_r) begin
      div_r <= div_r << 1;
      rem_r <= (sh >= {1'b0, dsr_r}) ? sub[MW-1:0] : sh[MW-1:0];
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

FILE: sv/bfiq_store.sv
// Filter bit store: one-port-write, one-read synchronous memory with a clearing sweep.
`default_nettype none
module bfiq_store #(
  parameter int unsigned STORE_WORDS = 16384,
  parameter int unsigned AW          = 14
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [AW-1:0]               rd_addr,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [bfiq_pkg::WORD_W-1:0] wr_data,
  output logic [bfiq_pkg::WORD_W-1:0] rd_data,
  output logic                        clearing
);
  import bfiq_pkg::*;

  logic [WORD_W-1:0] mem [STORE_WORDS];
  logic [WORD_W-1:0] rd_data_r;
  logic [AW-1:0]     clr_addr_r;
  logic              clr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == AW'(STORE_WORDS-1)) begin
        clr_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_r) begin
      mem[clr_addr_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data  = rd_data_r;
  assign clearing = clr_r;

endmodule
`default_nettype wire

FILE: sv/bloom_filter_insert_query.sv
// Top level of the Bloom filter engine: control sequencer, probe index walk and ports.
// Keys come one byte per request; a byte that is not the last is accepted and busy stays
// low. The last byte carries the command (0 add, 1 check) and raises busy while the probes run:
// three passes of the bit-serial remainder unit form the start index, the probe step and the
// wrap correction, then each probe passes through a read state and a write-back state on the
// bit store (only an add writes), up to the last probe; a check may end at its first clear
// bit. The result appears on out_valid for exactly one cycle and cannot be held off.
// After reset the store is cleared one 64-bit word per cycle (16384 words by default) with
// busy high; configuration writes are taken at any time but must only be issued while the
// block is idle.
`default_nettype none
module bloom_filter_insert_query #(
  parameter int unsigned MAX_FILTER_BITS = bfiq_pkg::MAX_FILTER_BITS_DEF,
  parameter int unsigned MAX_PROBES      = bfiq_pkg::MAX_PROBES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_command,
  input  logic [7:0]                       in_key_byte,
  input  logic                             in_last_byte,
  output logic                             out_valid,
  output logic                             out_was_check,
  output logic                             out_maybe_present,
  input  logic                             cfg_we,
  input  logic [bfiq_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bfiq_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import bfiq_pkg::*;

  localparam int unsigned MW          = $clog2(MAX_FILTER_BITS + 1);
  localparam int unsigned STORE_WORDS = (MAX_FILTER_BITS + WORD_W - 1) / WORD_W;
  localparam int unsigned AW          = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int unsigned PW          = $clog2(MAX_PROBES + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MODA,
    S_MODB,
    S_MODR,
    S_RD,
    S_WR
  } state_t;

  state_t state_r;

  logic [NUM_BITS_W-1:0]    num_bits_r;
  logic [HASH_COUNT_W-1:0]  hash_count_r;

  logic [31:0]       fb32;
  logic [31:0]       m32;
  logic [MW-1:0]     m_eff;
  logic [7:0]        hc8;
  logic [7:0]        k8;
  logic [PW-1:0]     k_eff;

  logic              accept;
  logic [HASH_W-1:0] djb_nxt;
  logic [HASH_W-1:0] sdbm_nxt;

  logic [HASH_W-1:0] a_r;
  logic [HASH_W-1:0] b_r;
  logic [HASH_W-1:0] acc_r;
  logic              carry_r;
  logic              cmd_r;
  logic [MW-1:0]     am_r;
  logic [MW-1:0]     bm_r;
  logic [MW-1:0]     wrap_r;
  logic [MW-1:0]     idx_r;
  logic [MW-1:0]     t_r;
  logic [PW-1:0]     pc_r;
  logic              out_valid_r;
  logic              out_was_check_r;
  logic              out_maybe_r;

  logic              mod_go;
  logic [HASH_W-1:0] mod_dividend;
  logic              mod_done;
  logic [MW-1:0]     mod_rem;

  logic [MW:0]       rem_inc;
  logic [MW-1:0]     wrap_nxt;
  logic [MW:0]       idx_sum;
  logic [MW:0]       idx_wrap;
  logic [MW-1:0]     t_nxt;
  logic [HASH_W:0]   acc_sum;
  logic [MW:0]       idx_fix;
  logic [MW-1:0]     idx_nxt;

  logic [AW-1:0]     word_addr;
  logic              st_wr_en;
  logic [WORD_W-1:0] st_rd_data;
  logic [WORD_W-1:0] bit_mask;
  logic              clearing;
  logic              bit_set;
  logic              last_probe;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_bits_r    <= NUM_BITS_RST;
      hash_count_r  <= HASH_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NUM_BITS:    num_bits_r    <= cfg_wdata[NUM_BITS_W-1:0];
        REG_HASH_COUNT:  hash_count_r  <= cfg_wdata[HASH_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Zero and oversized settings are clamped into range.
  always_comb begin
    fb32 = {{(32-NUM_BITS_W){1'b0}}, num_bits_r};
    m32  = fb32;
    if (fb32 == 32'd0) m32 = 32'd1;
    if (fb32 > MAX_FILTER_BITS) m32 = MAX_FILTER_BITS;
    m_eff = m32[MW-1:0];
    hc8 = {{(8-HASH_COUNT_W){1'b0}}, hash_count_r};
    k8  = hc8;
    if (hc8 == 8'd0) k8 = 8'd1;
    if (hc8 > MAX_PROBES) k8 = 8'(MAX_PROBES);
    k_eff = k8[PW-1:0];
  end

  assign accept = start && !busy;

  bfiq_hash u_hash (
    .clk      (clk),
    .rst_n    (rst_n),
    .upd      (accept),
    .key_byte (in_key_byte),
    .last_byte(in_last_byte),
    .djb_nxt  (djb_nxt),
    .sdbm_nxt (sdbm_nxt)
  );

  // The remainder unit runs three times: a mod m, b mod m, then (2^64 - 1) mod m.
  always_comb begin
    mod_go       = 1'b0;
    mod_dividend = djb_nxt;
    unique case (state_r)
      S_IDLE: mod_go = accept && in_last_byte;
      S_MODA: begin
        mod_go       = mod_done;
        mod_dividend = b_r;
      end
      S_MODB: begin
        mod_go       = mod_done;
        mod_dividend = '1;
      end
      default: ;
    endcase
  end

  bfiq_modulo #(.MW(MW)) u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (mod_go),
    .dividend(mod_dividend),
    .divisor (m_eff),
    .done    (mod_done),
    .rem     (mod_rem)
  );

  // 2^64 mod m is one more than (2^64 - 1) mod m, folded back below m.
  assign rem_inc  = {1'b0, mod_rem} + 1'b1;
  assign wrap_nxt = (rem_inc == {1'b0, m_eff}) ? '0 : rem_inc[MW-1:0];

  // Step the index by b mod m; when the 64-bit sum wraps, take 2^64 mod m off again.
  assign idx_sum  = {1'b0, idx_r} + {1'b0, bm_r};
  assign idx_wrap = idx_sum - {1'b0, m_eff};
  assign t_nxt    = (idx_sum >= {1'b0, m_eff}) ? idx_wrap[MW-1:0] : idx_sum[MW-1:0];
  assign acc_sum  = {1'b0, acc_r} + {1'b0, b_r};
  assign idx_fix  = (t_r >= wrap_r) ? ({1'b0, t_r} - {1'b0, wrap_r})
                                    : ({1'b0, t_r} + {1'b0, m_eff} - {1'b0, wrap_r});
  assign idx_nxt  = carry_r ? idx_fix[MW-1:0] : t_r;

  assign word_addr  = idx_r[AW+5:6];
  assign bit_mask   = {{(WORD_W-1){1'b0}}, 1'b1} << idx_r[5:0];
  assign bit_set    = (st_rd_data & bit_mask) != '0;
  assign st_wr_en   = (state_r == S_WR) && !cmd_r;
  assign last_probe = (pc_r == k_eff - 1'b1);

  bfiq_store #(.STORE_WORDS(STORE_WORDS), .AW(AW)) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (word_addr),
    .wr_en   (st_wr_en),
    .wr_addr (word_addr),
    .wr_data (st_rd_data | bit_mask),
    .rd_data (st_rd_data),
    .clearing(clearing)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      out_valid_r     <= 1'b0;
      out_was_check_r <= 1'b0;
      out_maybe_r     <= 1'b0;
      pc_r            <= '0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept && in_last_byte) begin
            a_r     <= djb_nxt;
            b_r     <= sdbm_nxt;
            cmd_r   <= in_command;
            state_r <= S_MODA;
          end
        end
        S_MODA: begin
          if (mod_done) begin
            am_r    <= mod_rem;
            state_r <= S_MODB;
          end
        end
        S_MODB: begin
          if (mod_done) begin
            bm_r    <= mod_rem;
            state_r <= S_MODR;
          end
        end
        S_MODR: begin
          if (mod_done) begin
            wrap_r  <= wrap_nxt;
            idx_r   <= am_r;
            acc_r   <= a_r;
            pc_r    <= '0;
            state_r <= S_RD;
          end
        end
        S_RD: begin
          t_r     <= t_nxt;
          acc_r   <= acc_sum[HASH_W-1:0];
          carry_r <= acc_sum[HASH_W];
          state_r <= S_WR;
        end
        S_WR: begin
          if ((cmd_r && !bit_set) || last_probe) begin
            out_valid_r     <= 1'b1;
            out_was_check_r <= cmd_r;
            out_maybe_r     <= cmd_r && bit_set;
            pc_r            <= '0;
            state_r         <= S_IDLE;
          end else begin
            idx_r   <= idx_nxt;
            pc_r    <= pc_r + 1'b1;
            state_r <= S_RD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy              = clearing || (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_was_check     = out_was_check_r;
  assign out_maybe_present = out_maybe_r;

  // A byte that does not end a key never holds the block off.
  a_mid_byte_free: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_last_byte) |=> !busy)
    else $error("busy raised after a non-final key byte");

  // An add is acknowledged without a membership answer.
  a_add_no_present: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_was_check) |-> !out_maybe_present)
    else $error("add result reports a present key");

  // Every probe index stays inside the filter in use.
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |-> (idx_r < m_eff))
    else $error("probe index outside the filter");

  // The probe count never passes the configured number of probes.
  a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR) |-> (pc_r < k_eff))
    else $error("probe counter beyond hash count");

  // A result is only produced by the last cycle of a probe walk.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == S_WR))
    else $error("result outside a probe walk");

endmodule
`default_nettype wire

FILE: bench/tb.sv
// Self-checking bench for the Bloom filter engine: random and directed key streams.
`default_nettype none

class bloom_scoreboard;
  typedef struct {
    bit was_check;
    bit maybe_present;
  } answer_t;

  bit [63:0] words[];
  bit [63:0] djb2_acc;
  bit [63:0] sdbm_acc;
  bit [20:0] num_bits;
  bit [5:0]  hash_count;
  answer_t   answers[$];
  int        errors;
  int        mismatches;

  function new();
    words = new[bfiq_pkg::MAX_FILTER_BITS_DEF / 64];
    djb2_acc = bfiq_pkg::DJB2_SEED;
    sdbm_acc = bfiq_pkg::SDBM_SEED;
    num_bits = bfiq_pkg::NUM_BITS_RST;
    hash_count = bfiq_pkg::HASH_COUNT_RST;
  endfunction

  function void write_reg(bit [1:0] index, bit [20:0] value);
    if (index == bfiq_pkg::REG_NUM_BITS) num_bits = value;
    else if (index == bfiq_pkg::REG_HASH_COUNT) hash_count = value[5:0];
  endfunction

  function int pending();
    return answers.size();
  endfunction

  // Notes an accepted request and predicts its answer when the key ends.
  function void note_request(bit cmd, bit [7:0] key_byte, bit last);
    bit [63:0] m;
    bit [63:0] k;
    bit [63:0] i;
    bit [63:0] idx;
    bit [63:0] w;
    bit        all_set;
    answer_t   ans;
    djb2_acc = (djb2_acc << 5) + djb2_acc + key_byte;
    sdbm_acc = key_byte + (sdbm_acc << 6) + (sdbm_acc << 16) - sdbm_acc;
    if (!last) return;
    m = 64'(num_bits);
    if (m == 0) m = 1;
    if (m > bfiq_pkg::MAX_FILTER_BITS_DEF) m = 64'(bfiq_pkg::MAX_FILTER_BITS_DEF);
    k = 64'(hash_count);
    if (k == 0) k = 1;
    if (k > bfiq_pkg::MAX_PROBES_DEF) k = 64'(bfiq_pkg::MAX_PROBES_DEF);
    all_set = 1;
    for (i = 0; i < k; i++) begin
      idx = djb2_acc + i * sdbm_acc;
      idx = idx % m;
      w = (idx >> 6) % words.size();
      if (!cmd) begin
        words[w][idx[5:0]] = 1'b1;
      end else if (!words[w][idx[5:0]]) begin
        all_set = 0;
        break;
      end
    end
    djb2_acc = bfiq_pkg::DJB2_SEED;
    sdbm_acc = bfiq_pkg::SDBM_SEED;
    ans.was_check = cmd;
    ans.maybe_present = cmd && all_set;
    answers.push_back(ans);
  endfunction

  function void check_answer(bit was_check, bit maybe_present);
    answer_t exp_ans;
    if (answers.size() == 0) begin
      errors++;
      mismatches++;
      if (mismatches <= 10) $display("Unexpected result: was_check=%0b maybe_present=%0b",
                                     was_check, maybe_present);
      return;
    end
    exp_ans = answers.pop_front();
    if (exp_ans.was_check !== was_check || exp_ans.maybe_present !== maybe_present) begin
      errors++;
      mismatches++;
      if (mismatches <= 10)
        $display("Mismatch: expected was_check=%0b maybe_present=%0b, got %0b %0b",
                 exp_ans.was_check, exp_ans.maybe_present, was_check, maybe_present);
    end
  endfunction
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    bit [47:0] bytes;
    int        len;
  } key_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_command = 1'b0;
  logic [7:0]  in_key_byte = '0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_was_check;
  logic        out_maybe_present;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [20:0] cfg_wdata = '0;

  bloom_scoreboard filter_model;
  key_t            added_keys[$];
  bit              no_gaps;

  bloom_filter_insert_query DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_key_byte(in_key_byte), .in_last_byte(in_last_byte),
    .out_valid(out_valid), .out_was_check(out_was_check),
    .out_maybe_present(out_maybe_present),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) filter_model.check_answer(out_was_check, out_maybe_present);
  end

  // Called at a rising edge; returns at the edge that accepted the request.
  task automatic send_byte(bit cmd, bit [7:0] key_byte, bit last);
    if (!no_gaps && $urandom_range(99) < 18) begin
      start <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    start <= 1'b1;
    in_command <= cmd;
    in_key_byte <= key_byte;
    in_last_byte <= last;
    do @(posedge clk); while (busy);
    filter_model.note_request(cmd, key_byte, last);
  endtask

  task automatic send_key(key_t key, bit cmd);
    for (int i = 0; i < key.len; i++)
      send_byte(1'($urandom_range(1)), key.bytes[8*i +: 8], i == key.len - 1 ? cmd : 1'b0);
  endtask

  task automatic send_key_cmd(key_t key, bit cmd);
    for (int i = 0; i < key.len; i++) begin
      if (i == key.len - 1) send_byte(cmd, key.bytes[8*i +: 8], 1'b1);
      else send_byte(1'($urandom_range(1)), key.bytes[8*i +: 8], 1'b0);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (filter_model.pending() > 0 || busy);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(bfiq_pkg::reg_index_t index, bit [20:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    filter_model.write_reg(index, value);
  endtask

  task automatic write_raw(bit [1:0] index, bit [20:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    filter_model.write_reg(index, value);
  endtask

  function automatic key_t random_key();
    key_t key;
    key.len = $urandom_range(6, 1);
    key.bytes = 48'({$urandom(), $urandom()});
    return key;
  endfunction

  task automatic random_phase(int count);
    key_t key;
    int   sent;
    sent = 0;
    while (sent < count) begin
      no_gaps = (sent > count / 3 && sent < count / 2);
      if ($urandom_range(1) && added_keys.size() > 0) begin
        key = added_keys[$urandom_range(added_keys.size() - 1)];
        send_key_cmd(key, 1'b1);
      end else begin
        key = random_key();
        if ($urandom_range(1)) begin
          send_key_cmd(key, 1'b0);
          added_keys.push_back(key);
        end else begin
          send_key_cmd(key, 1'b1);
        end
      end
      sent += key.len;
    end
    no_gaps = 0;
  endtask

  initial begin
    key_t key;
    filter_model = new();
    no_gaps = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    // The store clears itself after reset with busy high.
    drain();

    key.len = 1; key.bytes = 48'h00;
    send_key_cmd(key, 1'b1);
    send_key_cmd(key, 1'b0);
    send_key_cmd(key, 1'b1);
    key.bytes = 48'hFF;
    send_key_cmd(key, 1'b0);
    send_key_cmd(key, 1'b1);
    // The command bit of a byte that is not the last must be ignored.
    key.len = 6; key.bytes = 48'hFF00_FF00_FF00;
    send_key(key, 1'b0);
    send_key_cmd(key, 1'b1);
    key.bytes = 48'h5A5A_A5A5_0F0F;
    send_key_cmd(key, 1'b1);

    random_phase(180);
    write_reg(bfiq_pkg::REG_NUM_BITS, 21'd1);
    write_reg(bfiq_pkg::REG_HASH_COUNT, 21'd1);
    random_phase(60);
    write_reg(bfiq_pkg::REG_NUM_BITS, 21'd0);
    write_reg(bfiq_pkg::REG_HASH_COUNT, 21'd0);
    random_phase(60);
    write_reg(bfiq_pkg::REG_NUM_BITS, 21'h1FFFFF);
    write_reg(bfiq_pkg::REG_HASH_COUNT, 21'h3F);
    random_phase(150);
    // Writes to indexes beyond the last register change nothing.
    write_raw(2'd2, 21'd5);
    write_raw(2'd3, 21'd9);
    write_reg(bfiq_pkg::REG_NUM_BITS, 21'd64);
    write_reg(bfiq_pkg::REG_HASH_COUNT, 21'd32);
    random_phase(120);
    write_reg(bfiq_pkg::REG_NUM_BITS, 21'd1000);
    write_reg(bfiq_pkg::REG_HASH_COUNT, 21'd5);
    random_phase(150);
    write_reg(bfiq_pkg::REG_NUM_BITS, 21'h100000);
    write_reg(bfiq_pkg::REG_HASH_COUNT, 21'd33);
    random_phase(150);

    drain();
    repeat (20) @(posedge clk);
    if (filter_model.pending() > 0) filter_model.errors++;
    if (filter_model.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule
`default_nettype wire
